[design/brs_pkg.sv]
`default_nettype none
package brs_pkg;

  // Store geometry and fixed-point format.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 14;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  // Field widths.
  localparam int COORD_W    = 12;
  localparam int PIXEL_W    = 8;
  localparam int SIZE_W     = 9;
  localparam int STEP_W     = 22;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;
  localparam int POS_W      = COORD_W + STEP_W;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_PRODUCE = 1'b1
  } brs_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 2'd0,
    CFG_SOURCE_HEIGHT = 2'd1,
    CFG_STEP_X        = 2'd2,
    CFG_STEP_Y        = 2'd3
  } brs_cfg_idx_t;

  // One classified word between the front and the back. For a load, x0/y0
  // hold the store column and row and pixel the value to write.
  typedef struct packed {
    brs_cmd_t               cmd;
    logic [XW-1:0]          x0;
    logic [XW-1:0]          x1;
    logic [YW-1:0]          y0;
    logic [YW-1:0]          y1;
    logic [FRAC_BITS-1:0]   fx;
    logic [FRAC_BITS-1:0]   fy;
    logic [COORD_W-1:0]     dest_x;
    logic [COORD_W-1:0]     dest_y;
    logic [PIXEL_W-1:0]     pixel;
  } brs_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } brs_qstat_t;

endpackage
`default_nettype wire

[design/brs_front.sv]
`default_nettype none
module brs_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [brs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [brs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic                              in_command,
  input  wire logic [brs_pkg::COORD_W-1:0]       in_coord_x,
  input  wire logic [brs_pkg::COORD_W-1:0]       in_coord_y,
  input  wire logic [brs_pkg::PIXEL_W-1:0]       in_pixel_in,
  input  wire brs_pkg::brs_qstat_t               q_stat,
  output logic                                   q_push,
  output brs_pkg::brs_entry_t                    q_entry
);

  localparam int LIM_W = 13;
  localparam int FB    = brs_pkg::FRAC_BITS;
  localparam int XW    = brs_pkg::XW;
  localparam int YW    = brs_pkg::YW;
  localparam int POS_W = brs_pkg::POS_W;

  // Last usable index for a size register: zero acts as one, and a value
  // above the store limit acts as the limit.
  function automatic logic [LIM_W-1:0] last_of(logic [brs_pkg::SIZE_W-1:0] v,
                                               logic [LIM_W-1:0] maxv);
    logic [LIM_W-1:0] lim;
    lim = LIM_W'(v);
    if (v == '0) begin
      lim = LIM_W'(1);
    end else if (LIM_W'(v) > maxv) begin
      lim = maxv;
    end
    return lim - LIM_W'(1);
  endfunction

  logic [XW-1:0]               last_x_r;
  logic [YW-1:0]               last_y_r;
  logic [brs_pkg::STEP_W-1:0]  step_x_r;
  logic [brs_pkg::STEP_W-1:0]  step_y_r;

  logic                        s_valid_r;
  brs_pkg::brs_cmd_t           s_cmd_r;
  logic [POS_W-1:0]            s_pos_x_r;
  logic [POS_W-1:0]            s_pos_y_r;
  logic [brs_pkg::COORD_W-1:0] s_cx_r;
  logic [brs_pkg::COORD_W-1:0] s_cy_r;
  logic [brs_pkg::PIXEL_W-1:0] s_pix_r;

  logic                        accept;
  logic                        drop;
  logic                        drain;
  logic [LIM_W-1:0]            cfg_last_x;
  logic [LIM_W-1:0]            cfg_last_y;
  logic [POS_W-1:0]            lim_x;
  logic [POS_W-1:0]            lim_y;
  logic [POS_W-1:0]            pos_x;
  logic [POS_W-1:0]            pos_y;
  logic [XW-1:0]               x0;
  logic [YW-1:0]               y0;

  assign cfg_last_x = last_of(cfg_wdata[brs_pkg::SIZE_W-1:0], LIM_W'(brs_pkg::MAX_WIDTH));
  assign cfg_last_y = last_of(cfg_wdata[brs_pkg::SIZE_W-1:0], LIM_W'(brs_pkg::MAX_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= XW'(brs_pkg::MAX_WIDTH - 1);
      last_y_r <= YW'(brs_pkg::MAX_HEIGHT - 1);
      step_x_r <= brs_pkg::STEP_W'(1 << FB);
      step_y_r <= brs_pkg::STEP_W'(1 << FB);
    end else if (cfg_wr_en) begin
      unique case (brs_pkg::brs_cfg_idx_t'(cfg_index))
        brs_pkg::CFG_SOURCE_WIDTH: begin
          last_x_r <= cfg_last_x[XW-1:0];
        end
        brs_pkg::CFG_SOURCE_HEIGHT: begin
          last_y_r <= cfg_last_y[YW-1:0];
        end
        brs_pkg::CFG_STEP_X: step_x_r <= cfg_wdata[brs_pkg::STEP_W-1:0];
        brs_pkg::CFG_STEP_Y: step_y_r <= cfg_wdata[brs_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // A load that falls outside the store is dropped here and never queued.
  assign drop  = (s_cmd_r == brs_pkg::CMD_LOAD) &&
                 ((s_cx_r >= brs_pkg::COORD_W'(brs_pkg::MAX_WIDTH)) ||
                  (s_cy_r >= brs_pkg::COORD_W'(brs_pkg::MAX_HEIGHT)));
  assign drain   = s_valid_r && (drop || !q_stat.full);
  assign in_full = s_valid_r && !drain;
  assign accept  = in_push && !in_full;
  assign q_push  = s_valid_r && !drop && !q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (accept) begin
      s_valid_r <= 1'b1;
    end else if (drain) begin
      s_valid_r <= 1'b0;
    end
  end

  // The scaling multiply sits right after the input ports.
  always_ff @(posedge clk) begin
    if (accept) begin
      s_cmd_r   <= brs_pkg::brs_cmd_t'(in_command);
      s_pos_x_r <= POS_W'(in_coord_x) * POS_W'(step_x_r);
      s_pos_y_r <= POS_W'(in_coord_y) * POS_W'(step_y_r);
      s_cx_r    <= in_coord_x;
      s_cy_r    <= in_coord_y;
      s_pix_r   <= in_pixel_in;
    end
  end

  always_comb begin
    lim_x = POS_W'(last_x_r) << FB;
    lim_y = POS_W'(last_y_r) << FB;
    pos_x = (s_pos_x_r > lim_x) ? lim_x : s_pos_x_r;
    pos_y = (s_pos_y_r > lim_y) ? lim_y : s_pos_y_r;
    x0    = pos_x[FB +: XW];
    y0    = pos_y[FB +: YW];

    q_entry.cmd    = s_cmd_r;
    q_entry.dest_x = s_cx_r;
    q_entry.dest_y = s_cy_r;
    q_entry.pixel  = s_pix_r;
    if (s_cmd_r == brs_pkg::CMD_LOAD) begin
      q_entry.x0 = s_cx_r[XW-1:0];
      q_entry.y0 = s_cy_r[YW-1:0];
      q_entry.x1 = s_cx_r[XW-1:0];
      q_entry.y1 = s_cy_r[YW-1:0];
      q_entry.fx = '0;
      q_entry.fy = '0;
    end else begin
      q_entry.x0 = x0;
      q_entry.y0 = y0;
      q_entry.x1 = (x0 < last_x_r) ? XW'(x0 + XW'(1)) : last_x_r;
      q_entry.y1 = (y0 < last_y_r) ? YW'(y0 + YW'(1)) : last_y_r;
      q_entry.fx = pos_x[FB-1:0];
      q_entry.fy = pos_y[FB-1:0];
    end
  end

endmodule
`default_nettype wire

[design/brs_queue.sv]
`default_nettype none
module brs_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire brs_pkg::brs_entry_t  push_entry,
  input  wire logic                 pop,
  output brs_pkg::brs_entry_t       head,
  output brs_pkg::brs_qstat_t       stat
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  brs_pkg::brs_entry_t slot_r [DEPTH];
  logic [PW-1:0]       wr_ptr_r;
  logic [PW-1:0]       rd_ptr_r;
  logic [PW:0]         count_r;
  logic                do_push;
  logic                do_pop;

  assign stat.full  = (count_r == (PW+1)'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

[design/brs_back.sv]
`default_nettype none
module brs_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire brs_pkg::brs_entry_t            head,
  input  wire brs_pkg::brs_qstat_t            q_stat,
  output logic                                q_pop,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic [brs_pkg::PIXEL_W-1:0]         out_pixel_out,
  output logic [brs_pkg::COORD_W-1:0]         out_dest_x,
  output logic [brs_pkg::COORD_W-1:0]         out_dest_y
);

  localparam int FB        = brs_pkg::FRAC_BITS;
  localparam int PW        = brs_pkg::PIXEL_W;
  localparam int CW        = brs_pkg::COORD_W;
  localparam int MEM_DEPTH = brs_pkg::MAX_WIDTH * brs_pkg::MAX_HEIGHT;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int BW        = FB + PW + 1;
  localparam int OQ_DEPTH  = 2;
  localparam int OQ_PW     = $clog2(OQ_DEPTH);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(brs_pkg::MAX_WIDTH);

  typedef struct packed {
    logic [PW-1:0] pixel;
    logic [CW-1:0] dest_x;
    logic [CW-1:0] dest_y;
  } brs_result_t;

  // Rounded blend of two pixels with a fractional weight on the second.
  function automatic logic [PW-1:0] blend(logic [PW-1:0] a, logic [PW-1:0] b,
                                          logic [FB-1:0] f);
    logic [FB:0]   w0;
    logic [BW-1:0] sum;
    w0  = (FB+1)'(1 << FB) - (FB+1)'(f);
    sum = BW'(w0) * BW'(a) + BW'(f) * BW'(b) + BW'(1 << (FB - 1));
    return sum[FB +: PW];
  endfunction

  logic [PW-1:0]   mem [MEM_DEPTH];

  logic            phase_r;
  logic            adv;
  logic            issue_load;
  logic            issue_row0;
  logic            issue_row1;
  logic [AW-1:0]   row_base;
  logic [AW-1:0]   addr_a;
  logic [AW-1:0]   addr_b;

  logic [PW-1:0]   rd_a_r;
  logic [PW-1:0]   rd_b_r;
  logic            s1_valid_r;
  logic            s1_row1_r;
  logic [FB-1:0]   s1_fx_r;
  logic [FB-1:0]   s1_fy_r;
  logic [CW-1:0]   s1_dx_r;
  logic [CW-1:0]   s1_dy_r;

  logic            s2_valid_r;
  logic            s2_row1_r;
  logic [PW-1:0]   s2_h_r;
  logic [FB-1:0]   s2_fy_r;
  logic [CW-1:0]   s2_dx_r;
  logic [CW-1:0]   s2_dy_r;
  logic [PW-1:0]   top_r;

  brs_result_t      oq_slot_r [OQ_DEPTH];
  logic [OQ_PW-1:0] oq_wr_r;
  logic [OQ_PW-1:0] oq_rd_r;
  logic [OQ_PW:0]   oq_count_r;
  logic             oq_full;
  logic             oq_push;
  logic             oq_pop;
  brs_result_t      oq_head;

  assign oq_full = (oq_count_r == (OQ_PW+1)'(OQ_DEPTH));
  assign oq_push = s2_valid_r && s2_row1_r && !oq_full;
  assign oq_pop  = out_pop && !out_empty;

  // The whole back pipeline freezes while a finished pixel finds no room.
  assign adv = !(s2_valid_r && s2_row1_r && oq_full);

  // A produce word stays at the queue head while its first row and then its
  // second row issue. A load is popped as soon as it issues.
  assign issue_load = adv && !q_stat.empty && !phase_r && (head.cmd == brs_pkg::CMD_LOAD);
  assign issue_row0 = adv && !q_stat.empty && !phase_r && (head.cmd == brs_pkg::CMD_PRODUCE);
  assign issue_row1 = adv && phase_r;
  assign q_pop      = issue_load || issue_row1;

  assign row_base = AW'(phase_r ? head.y1 : head.y0) * ROW_STRIDE;
  assign addr_a   = AW'(row_base + AW'(head.x0));
  assign addr_b   = AW'(row_base + AW'(head.x1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (issue_row0) begin
      phase_r <= 1'b1;
    end else if (issue_row1) begin
      phase_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_load) begin
      mem[addr_a] <= head.pixel;
    end
    if (adv) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= issue_row0 || issue_row1;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_row1_r <= phase_r;
      s1_fx_r   <= head.fx;
      s1_fy_r   <= head.fy;
      s1_dx_r   <= head.dest_x;
      s1_dy_r   <= head.dest_y;
      s2_row1_r <= s1_row1_r;
      s2_h_r    <= blend(rd_a_r, rd_b_r, s1_fx_r);
      s2_fy_r   <= s1_fy_r;
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      if (s2_valid_r && !s2_row1_r) begin
        top_r <= s2_h_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r    <= '0;
      oq_rd_r    <= '0;
      oq_count_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + OQ_PW'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + OQ_PW'(1);
      end
      if (oq_push && !oq_pop) begin
        oq_count_r <= oq_count_r + (OQ_PW+1)'(1);
      end else if (oq_pop && !oq_push) begin
        oq_count_r <= oq_count_r - (OQ_PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_slot_r[oq_wr_r] <= '{pixel:  blend(top_r, s2_h_r, s2_fy_r),
                              dest_x: s2_dx_r,
                              dest_y: s2_dy_r};
    end
  end

  assign oq_head       = oq_slot_r[oq_rd_r];
  assign out_empty     = (oq_count_r == '0);
  assign out_pixel_out = oq_head.pixel;
  assign out_dest_x    = oq_head.dest_x;
  assign out_dest_y    = oq_head.dest_y;

endmodule
`default_nettype wire

[design/bilinear_gray_resampler.sv]
// Bilinear gray resampler. An 8-bit source image of up to 256 x 256 pixels
// lives in an internal store. Words enter on the input queue port (push,
// full): a load word writes one source pixel, a produce word names a
// destination pixel. Each produce word yields one result word on the output
// queue port (empty, pop) carrying the interpolated pixel and the echoed
// destination coordinates; load words yield nothing. Results leave in order.
// The front registers each word and scales its coordinates by the step
// registers, clamps and classifies it, and places it in a four-word queue.
// The back reads the four neighbors from the store, two per cycle while it
// is not frozen, first row then second row, blends them horizontally, then
// vertically, and fills a two-word result queue. A produce word holds the
// store read ports for both of its rows and a load word its write port,
// which sets the sustained rate.
// Reset (synchronous, rst_n low) empties both queues and restores the
// configuration to a full 256 x 256 image with unit steps; the store keeps
// no defined content until loaded. When the receiver stops popping, the
// result queue fills, the back freezes, and full rises once the middle
// queue and the front register are taken. Configuration must be written only
// while the block is idle; the block itself does not enforce this.
`default_nettype none
module bilinear_gray_resampler (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [brs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [brs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic                            in_command,
  input  wire logic [brs_pkg::COORD_W-1:0]     in_coord_x,
  input  wire logic [brs_pkg::COORD_W-1:0]     in_coord_y,
  input  wire logic [brs_pkg::PIXEL_W-1:0]     in_pixel_in,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [brs_pkg::PIXEL_W-1:0]          out_pixel_out,
  output logic [brs_pkg::COORD_W-1:0]          out_dest_x,
  output logic [brs_pkg::COORD_W-1:0]          out_dest_y
);

  // Classified words flow from the front through the queue to the back.
  brs_pkg::brs_entry_t front_entry;
  brs_pkg::brs_entry_t queue_head;
  brs_pkg::brs_qstat_t queue_stat;
  logic                front_push;
  logic                back_pop;

  brs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_command  (in_command),
    .in_coord_x  (in_coord_x),
    .in_coord_y  (in_coord_y),
    .in_pixel_in (in_pixel_in),
    .q_stat      (queue_stat),
    .q_push      (front_push),
    .q_entry     (front_entry)
  );

  brs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (front_push),
    .push_entry (front_entry),
    .pop        (back_pop),
    .head       (queue_head),
    .stat       (queue_stat)
  );

  // The back owns the pixel store and the result queue.
  brs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (queue_head),
    .q_stat        (queue_stat),
    .q_pop         (back_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_pixel_out (out_pixel_out),
    .out_dest_x    (out_dest_x),
    .out_dest_y    (out_dest_y)
  );

endmodule
`default_nettype wire

[verif/tb_bilinear_gray_resampler.sv]
module tb_bilinear_gray_resampler;
  timeunit 1ns;
  timeprecision 1ps;

  import brs_pkg::*;

  // Run shape. The cycle limit sits far above the slowest legal run. That run
  // has about a thousand words, each with the longest sender gap, the longest
  // receiver stall and its store reads, plus the long hold-off and the drain
  // between phases.
  localparam int unsigned NUM_PHASES   = 10;
  localparam int unsigned PHASE_ITEMS  = 93;
  localparam int unsigned DRAIN_GAP    = 16;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned END_WAIT     = 4000;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
  } result_t;

  typedef enum logic { ROW_WORD, ROW_SETTINGS } row_kind_t;
  typedef enum int { PRESS_NONE, PRESS_HOLD, PRESS_PAUSE } pressure_t;

  // One row of the directed script. A word row sends one input word. When
  // typed is set, the expected pixel is the typed value and not the
  // prediction. A settings row waits for the block to go idle and then
  // writes all four registers.
  typedef struct packed {
    row_kind_t          kind;
    brs_cmd_t           cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIXEL_W-1:0] pix;
    logic               typed;
    logic [PIXEL_W-1:0] typed_pix;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic [STEP_W-1:0]  sx;
    logic [STEP_W-1:0]  sy;
  } row_t;

  // All inputs start at known values. Reset is held low from time zero.
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  in_push     = 1'b0;
  logic                  in_command  = 1'b0;
  logic [COORD_W-1:0]    in_coord_x  = '0;
  logic [COORD_W-1:0]    in_coord_y  = '0;
  logic [PIXEL_W-1:0]    in_pixel_in = '0;
  logic                  out_pop     = 1'b0;
  logic                  in_full;
  logic                  out_empty;
  logic [PIXEL_W-1:0]    out_pixel_out;
  logic [COORD_W-1:0]    out_dest_x;
  logic [COORD_W-1:0]    out_dest_y;

  bilinear_gray_resampler u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_command    (in_command),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_pixel_in   (in_pixel_in),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_pixel_out (out_pixel_out),
    .out_dest_x    (out_dest_x),
    .out_dest_y    (out_dest_y)
  );

  always #10 clk = ~clk;

  // The testbench keeps its own copy of the source image and the registers.
  // It also records which store entries hold a value, so that no produce
  // word ever reads an entry that was never loaded.
  logic [PIXEL_W-1:0] image_mem [0:MAX_WIDTH*MAX_HEIGHT-1];
  bit                 image_written [0:MAX_WIDTH*MAX_HEIGHT-1];
  logic [SIZE_W-1:0]  width_reg  = SIZE_W'(256);
  logic [SIZE_W-1:0]  height_reg = SIZE_W'(256);
  logic [STEP_W-1:0]  stepx_reg  = STEP_W'(16384);
  logic [STEP_W-1:0]  stepy_reg  = STEP_W'(16384);

  // Results in flight, oldest first. The sender appends one entry when a
  // produce word is accepted, and the receiver checks each popped word
  // against the front entry.
  result_t pending_pixels [$];

  int unsigned errors        = 0;
  int unsigned sender_idle   = 10;
  int unsigned reader_idle   = 10;
  bit          calm          = 1'b0;
  bit          hold_request  = 1'b0;

  // Directed script. It starts at the reset settings (256 x 256, unit
  // steps), so a produce word at the origin reads the four corner entries
  // and a produce word far out clamps to the last pixel. Loads with a
  // coordinate past the store must change nothing. The word at column 256
  // of the last row would alias onto the origin if the store index wrapped.
  // Next comes a width of zero (it acts as one column) with an oversized
  // height, the largest step across and a zero step down. Last comes a
  // 2 x 2 image at half steps, which exercises real fractions and the
  // clamp of the right and lower neighbours to the image edge.
  localparam int unsigned SCRIPT_LEN = 25;
  row_t script [0:SCRIPT_LEN-1] = '{
    '{ROW_WORD, CMD_LOAD, 12'd0, 12'd0, 8'd255, 1'b0, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_LOAD, 12'd1, 12'd0, 8'd0, 1'b0, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_LOAD, 12'd0, 12'd1, 8'd0, 1'b0, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_LOAD, 12'd1, 12'd1, 8'd0, 1'b0, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_PRODUCE, 12'd0, 12'd0, 8'hA5, 1'b1, 8'd255, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_LOAD, 12'd255, 12'd255, 8'd200, 1'b0, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_PRODUCE, 12'd4095, 12'd4095, 8'h5A, 1'b1, 8'd200, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_LOAD, 12'd4095, 12'd4095, 8'd7, 1'b0, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_LOAD, 12'd256, 12'd255, 8'd9, 1'b0, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_LOAD, 12'd255, 12'd256, 8'd9, 1'b0, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_PRODUCE, 12'd4095, 12'd4095, 8'hFF, 1'b1, 8'd200, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_PRODUCE, 12'd0, 12'd0, 8'h00, 1'b1, 8'd255, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_SETTINGS, CMD_LOAD, 12'd0, 12'd0, 8'd0, 1'b0, 8'd0,
      9'd0, 9'd511, 22'h3FFFFF, 22'd0},
    '{ROW_WORD, CMD_PRODUCE, 12'd4095, 12'd4095, 8'hA5, 1'b1, 8'd255, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_PRODUCE, 12'd0, 12'd4095, 8'h5A, 1'b1, 8'd255, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_SETTINGS, CMD_LOAD, 12'd0, 12'd0, 8'd0, 1'b0, 8'd0,
      9'd2, 9'd2, 22'd8192, 22'd8192},
    '{ROW_WORD, CMD_LOAD, 12'd0, 12'd0, 8'd0, 1'b0, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_LOAD, 12'd1, 12'd0, 8'd255, 1'b0, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_LOAD, 12'd0, 12'd1, 8'd255, 1'b0, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_LOAD, 12'd1, 12'd1, 8'd0, 1'b0, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_PRODUCE, 12'd1, 12'd0, 8'hA5, 1'b0, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_PRODUCE, 12'd0, 12'd1, 8'h5A, 1'b0, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_PRODUCE, 12'd1, 12'd1, 8'hFF, 1'b0, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_PRODUCE, 12'd2, 12'd2, 8'h00, 1'b1, 8'd0, 9'd0, 9'd0, 22'd0, 22'd0},
    '{ROW_WORD, CMD_PRODUCE, 12'd3, 12'd0, 8'hA5, 1'b1, 8'd255, 9'd0, 9'd0, 22'd0, 22'd0}
  };

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // A size register of zero acts as one, and a value above the store
  // dimension acts as that dimension.
  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v,
                                           input int unsigned maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // Scales one coordinate by its step, clamps the position to the last used
  // column or row, and returns both neighbours and the fraction between
  // them. The upper neighbour never goes past the last column or row.
  function automatic void locate_axis(input logic [COORD_W-1:0] coord,
                                      input logic [STEP_W-1:0] step,
                                      input int unsigned last,
                                      output int unsigned lo,
                                      output int unsigned hi,
                                      output int unsigned frac);
    logic [63:0] pos;
    logic [63:0] cap;
    pos = 64'(coord) * 64'(step);
    cap = 64'(last) << FRAC_BITS;
    if (pos > cap) pos = cap;
    lo   = int'(pos >> FRAC_BITS);
    frac = int'(pos[FRAC_BITS-1:0]);
    hi   = (lo + 1 <= last) ? lo + 1 : last;
  endfunction

  // Weighted blend of two pixels, rounded half up.
  function automatic int unsigned mix(input int unsigned a, input int unsigned b,
                                      input int unsigned frac);
    return (((1 << FRAC_BITS) - frac) * a + frac * b + (1 << (FRAC_BITS - 1)))
           >> FRAC_BITS;
  endfunction

  function automatic int unsigned read_src(input int unsigned col,
                                           input int unsigned row);
    return image_mem[row * MAX_WIDTH + col];
  endfunction

  function automatic result_t resample_pixel(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y);
    int unsigned c0, c1, r0, r1, fx, fy, upper, lower;
    result_t     res;
    locate_axis(x, stepx_reg, eff_size(width_reg, MAX_WIDTH) - 1, c0, c1, fx);
    locate_axis(y, stepy_reg, eff_size(height_reg, MAX_HEIGHT) - 1, r0, r1, fy);
    upper = mix(read_src(c0, r0), read_src(c1, r0), fx);
    lower = mix(read_src(c0, r1), read_src(c1, r1), fx);
    res.pixel  = PIXEL_W'(mix(upper, lower, fy));
    res.dest_x = x;
    res.dest_y = y;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offers one word and returns at the edge that accepts it. The model is
  // updated at that point: the block works through words in order, so
  // predicting at acceptance matches what the back end will see.
  task automatic push_word(input brs_cmd_t cmd, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [PIXEL_W-1:0] pix,
                           input bit typed, input logic [PIXEL_W-1:0] typed_pix);
    result_t want;
    in_push     <= 1'b1;
    in_command  <= cmd;
    in_coord_x  <= x;
    in_coord_y  <= y;
    in_pixel_in <= pix;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (cmd == CMD_LOAD) begin
      if (x < MAX_WIDTH && y < MAX_HEIGHT) begin
        image_mem[y * MAX_WIDTH + x]     = pix;
        image_written[y * MAX_WIDTH + x] = 1'b1;
      end
    end else begin
      want = resample_pixel(x, y);
      if (typed) want.pixel = typed_pix;
      pending_pixels = {pending_pixels, want};
    end
  endtask

  // Random idle burst between words. While push is low the payload ports
  // carry junk, which the block must ignore.
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 99) < sender_idle) begin
      in_push     <= 1'b0;
      in_command  <= 1'($urandom_range(0, 1));
      in_coord_x  <= COORD_W'($urandom);
      in_coord_y  <= COORD_W'($urandom);
      in_pixel_in <= PIXEL_W'($urandom);
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Waits until every expected word has come back. Loads leave nothing to
  // wait for, so a further drain gap lets the last of them reach the store.
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // Writes all four registers on back-to-back cycles. This is only called
  // once the block is idle.
  task automatic apply_settings(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                                input logic [STEP_W-1:0] sx, input logic [STEP_W-1:0] sy);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SOURCE_WIDTH;
    cfg_wdata <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= CFG_SOURCE_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_index <= CFG_STEP_X;
    cfg_wdata <= CFG_DATA_W'(sx);
    @(posedge clk);
    cfg_index <= CFG_STEP_Y;
    cfg_wdata <= CFG_DATA_W'(sy);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wdata <= CFG_DATA_W'($urandom);
    width_reg  = w;
    height_reg = h;
    stepx_reg  = sx;
    stepy_reg  = sy;
  endtask

  // Before a produce word goes out, any of its four source entries that was
  // never loaded is loaded with a random value. This yields well-formed
  // load/produce sequences whose content is random.
  task automatic fill_neighbours(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                 output int unsigned loads);
    int unsigned c0, c1, r0, r1, fx, fy, col, row;
    locate_axis(x, stepx_reg, eff_size(width_reg, MAX_WIDTH) - 1, c0, c1, fx);
    locate_axis(y, stepy_reg, eff_size(height_reg, MAX_HEIGHT) - 1, r0, r1, fy);
    loads = 0;
    for (int k = 0; k < 4; k++) begin
      col = (k % 2 == 0) ? c0 : c1;
      row = (k < 2) ? r0 : r1;
      if (!image_written[row * MAX_WIDTH + col]) begin
        push_word(CMD_LOAD, COORD_W'(col), COORD_W'(row), PIXEL_W'($urandom_range(0, 255)),
                  1'b0, '0);
        sender_gap();
        loads++;
      end
    end
  endtask

  // Sizes mostly stay small, so that the loads needed to cover a region
  // stay cheap. Zero, the full store and oversized values also turn up.
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SIZE_W'(256);
      2: return SIZE_W'($urandom_range(257, 511));
      default: return SIZE_W'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {STEP_W{1'b1}};
      2: return STEP_W'($urandom);
      3: return STEP_W'(1 << FRAC_BITS);
      default: return STEP_W'($urandom_range(1024, 4 << FRAC_BITS));
    endcase
  endfunction

  // Most destination coordinates map inside the image, with a little
  // margin past its edge. The rest span the full field.
  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned size_eff,
                                                    input logic [STEP_W-1:0] step);
    int unsigned span;
    if (step == '0 || $urandom_range(0, 4) == 0) return COORD_W'($urandom_range(0, 4095));
    span = (size_eff << FRAC_BITS) / step + 1;
    if (span > 4095) span = 4095;
    return COORD_W'($urandom_range(0, span));
  endfunction

  // One random phase: new settings, then a mix of produce words (with the
  // loads they need), loads over the used region, loads anywhere in the
  // store, and a few loads outside the store that must change nothing.
  task automatic run_phase(input int unsigned target, input pressure_t press);
    int unsigned        done_items;
    int unsigned        loads;
    int unsigned        roll;
    int unsigned        w_eff;
    int unsigned        h_eff;
    bit                 pressed;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    settle();
    apply_settings(pick_size(), pick_size(), pick_step(), pick_step());
    w_eff = eff_size(width_reg, MAX_WIDTH);
    h_eff = eff_size(height_reg, MAX_HEIGHT);
    done_items = 0;
    pressed = 1'b0;
    while (done_items < target) begin
      if (!pressed && done_items >= target / 2) begin
        pressed = 1'b1;
        if (press == PRESS_HOLD) begin
          // The receiver stops popping for a long while and the sender keeps
          // offering words, so the queues fill up and full must rise.
          hold_request = 1'b1;
        end else if (press == PRESS_PAUSE) begin
          in_push <= 1'b0;
          @(posedge clk);
          while (pending_pixels.size() != 0) @(posedge clk);
        end
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        x = pick_coord(w_eff, stepx_reg);
        y = pick_coord(h_eff, stepy_reg);
        fill_neighbours(x, y, loads);
        push_word(CMD_PRODUCE, x, y, PIXEL_W'($urandom), 1'b0, '0);
        done_items += loads + 1;
      end else if (roll < 85) begin
        push_word(CMD_LOAD, COORD_W'($urandom_range(0, w_eff - 1)),
                  COORD_W'($urandom_range(0, h_eff - 1)),
                  PIXEL_W'($urandom_range(0, 255)), 1'b0, '0);
        done_items++;
      end else if (roll < 95) begin
        push_word(CMD_LOAD, COORD_W'($urandom_range(0, MAX_WIDTH - 1)),
                  COORD_W'($urandom_range(0, MAX_HEIGHT - 1)),
                  PIXEL_W'($urandom_range(0, 255)), 1'b0, '0);
        done_items++;
      end else begin
        // At least one coordinate lies past the store, so the load is dropped.
        x = COORD_W'($urandom_range(0, 4095));
        y = COORD_W'($urandom_range(MAX_HEIGHT, 4095));
        if ($urandom_range(0, 1) == 1) push_word(CMD_LOAD, y, x, PIXEL_W'($urandom), 1'b0, '0);
        else push_word(CMD_LOAD, x, y, PIXEL_W'($urandom), 1'b0, '0);
      end
      sender_gap();
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int unsigned waited;
    pressure_t   press;
    result_t     left;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_SETTINGS) begin
        settle();
        apply_settings(script[i].w, script[i].h, script[i].sx, script[i].sy);
      end else begin
        push_word(script[i].cmd, script[i].x, script[i].y, script[i].pix,
                  script[i].typed, script[i].typed_pix);
        sender_gap();
      end
    end

    // Each phase picks its own idling, from none at all to heavy. The final
    // phase runs with no idling on either side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      press = (p == 2) ? PRESS_HOLD : (p == 5) ? PRESS_PAUSE : PRESS_NONE;
      calm = (p == NUM_PHASES - 1);
      case ($urandom_range(0, 3))
        0: sender_idle = 0;
        1: sender_idle = 5;
        2: sender_idle = 20;
        default: sender_idle = 40;
      endcase
      case ($urandom_range(0, 3))
        0: reader_idle = 0;
        1: reader_idle = 5;
        2: reader_idle = 20;
        default: reader_idle = 40;
      endcase
      if (press == PRESS_HOLD) sender_idle = 0;
      run_phase(PHASE_ITEMS, press);
    end

    in_push <= 1'b0;
    waited = 0;
    while (pending_pixels.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      errors++;
      left = pending_pixels[0];
      $display("%0t: %0d expected words never arrived, oldest pixel %0d at (%0d,%0d)",
               $time, pending_pixels.size(), left.pixel, left.dest_x, left.dest_y);
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver side: random pop stalls, the long hold-off, and the checker.
  // Outputs are sampled right at the rising edge, before the block's own
  // updates for that edge land, so they hold the values that were accepted.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    result_t     want;
    stall_left = 0;
    hold_left = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (pending_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got pixel %0d at (%0d,%0d)",
                   $time, out_pixel_out, out_dest_x, out_dest_y);
        end else begin
          want = pending_pixels.pop_front();
          if (out_pixel_out !== want.pixel) begin
            errors++;
            $display("%0t: pixel_out expected %0d got %0d (dest %0d,%0d)",
                     $time, want.pixel, out_pixel_out, want.dest_x, want.dest_y);
          end
          if (out_dest_x !== want.dest_x) begin
            errors++;
            $display("%0t: dest_x expected %0d got %0d", $time, want.dest_x, out_dest_x);
          end
          if (out_dest_y !== want.dest_y) begin
            errors++;
            $display("%0t: dest_y expected %0d got %0d", $time, want.dest_y, out_dest_y);
          end
        end
      end

      // Decide pop for the next edge. Exactly one assignment per edge.
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < reader_idle) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
